// ===== src/dts_pkg.sv =====
// types and constants for the doctype token scanner
// no dependencies; used by doctype_token_scanner
package dts_pkg;

  typedef enum logic [3:0] {
    ST_IDLE         = 4'd0,
    ST_BEFORE_NAME  = 4'd1,
    ST_NAME         = 4'd2,
    ST_AFTER_NAME   = 4'd3,
    ST_KEYWORD      = 4'd4,
    ST_BEFORE_PUBID = 4'd5,
    ST_PUB_ID       = 4'd6,
    ST_AFTER_PUBID  = 4'd7,
    ST_SYS_ID       = 4'd8,
    ST_AFTER_SYSID  = 4'd9,
    ST_BOGUS        = 4'd10
  } scan_state_e;

  localparam logic       EV_SPAN = 1'b0;
  localparam logic       EV_END  = 1'b1;

  localparam logic [2:0] SPAN_NAME   = 3'd0;
  localparam logic [2:0] SPAN_PUB_KW = 3'd1;
  localparam logic [2:0] SPAN_SYS_KW = 3'd2;
  localparam logic [2:0] SPAN_PUB_ID = 3'd3;
  localparam logic [2:0] SPAN_SYS_ID = 3'd4;

  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;

  localparam logic [2:0] KW_LAST = 3'd5;

  typedef struct packed {
    logic        event_kind;
    logic [2:0]  span_kind;
    logic [31:0] span_begin;
    logic [31:0] span_length;
    logic [31:0] token_length;
    logic        quirks_mode;
    logic        last_event;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0C) || (c == 8'h0D) || (c == 8'h20);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
  endfunction

  // PUBLIC / SYSTEM, upper case
  function automatic logic [7:0] kw_char(input logic sys, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (idx)
      3'd0: ch = sys ? 8'h53 : 8'h50;
      3'd1: ch = sys ? 8'h59 : 8'h55;
      3'd2: ch = sys ? 8'h53 : 8'h42;
      3'd3: ch = sys ? 8'h54 : 8'h4C;
      3'd4: ch = sys ? 8'h45 : 8'h49;
      3'd5: ch = sys ? 8'h4D : 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/doctype_token_scanner.sv =====
// doctype token scanner: span and token-end events for a DOCTYPE body
// depends on dts_pkg
//
// usage
//   input channel: one document byte per item with its offset; start_token_i
//   marks the first byte after the DOCTYPE keyword and samples the offset of
//   the opening bracket. output channel: one event per item, either a span
//   (name, keyword or identifier) or the end of the token with its length
//   and quirks flag. a byte can cause zero, one or two events; last_event_o
//   marks the final event of a byte.
//   the events of a byte are written into the result queue when it is taken.
//   throughput: one byte per cycle while each byte yields at most one event
//   and the receiver does not stall; a byte that yields two events needs an
//   extra pop at the single output port of the four-entry result queue.
//   in_stall_o rises when the queue has fewer than two free entries, so a
//   stalled receiver backs up into the input side after a few items.
//   reset empties the queue and returns the scanner to idle, outside any
//   token; bytes seen while idle without a start are ignored.
module doctype_token_scanner
  import dts_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] byte_offset_i,
  input  logic        start_token_i,
  input  logic [31:0] tag_begin_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_kind_o,
  output logic [2:0]  span_kind_o,
  output logic [31:0] span_begin_o,
  output logic [31:0] span_length_o,
  output logic [31:0] token_length_o,
  output logic        quirks_mode_o,
  output logic        last_event_o
);

  localparam int OB = OFFSET_BITS;

  scan_state_e    state_q, state_d;
  logic [2:0]     kw_idx_q, kw_idx_d;
  logic           kw_sys_q, kw_sys_d;
  logic           q_single_q, q_single_d;
  logic [OB-1:0]  span_start_q, span_start_d;
  logic [OB-1:0]  tok_start_q, tok_start_d;
  logic           quirks_q, quirks_d;

  result_t        res0, res1;
  logic [1:0]     n_res;

  result_t        mem_q [4];
  logic [1:0]     wr_ptr_q, rd_ptr_q;
  logic [2:0]     count_q;

  logic           in_accept, out_pop;
  logic [OB-1:0]  off;
  logic [7:0]     c, up, quote_ch;
  scan_state_e    st;

  assign in_stall_o  = (count_q > 3'd2);
  assign out_valid_o = (count_q != 3'd0);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_pop     = out_valid_o & ~out_stall_i;

  assign off = OB'(byte_offset_i);
  assign c   = data_byte_i;
  assign up  = to_upper(data_byte_i);

  always_comb begin
    state_d      = state_q;
    kw_idx_d     = kw_idx_q;
    kw_sys_d     = kw_sys_q;
    q_single_d   = q_single_q;
    span_start_d = span_start_q;
    tok_start_d  = tok_start_q;
    quirks_d     = quirks_q;
    res0         = '0;
    res1         = '0;
    n_res        = 2'd0;

    // a start abandons whatever token was in progress
    if (start_token_i) begin
      tok_start_d  = OB'(tag_begin_offset_i);
      quirks_d     = 1'b0;
      kw_idx_d     = 3'd0;
      kw_sys_d     = 1'b0;
      q_single_d   = 1'b0;
      span_start_d = '0;
      state_d      = ST_BEFORE_NAME;
    end
    st       = state_d;
    quote_ch = q_single_d ? CH_SQUOT : CH_DQUOT;

    unique case (st)
      ST_BEFORE_NAME: begin
        if (!is_space(c)) begin
          if (c == CH_GT) begin
            quirks_d = 1'b1;
            n_res    = 2'd1;
            state_d  = ST_IDLE;
          end else begin
            span_start_d = off;
            state_d      = ST_NAME;
          end
        end
      end
      ST_NAME: begin
        if (c == CH_GT) begin
          res0.span_kind = SPAN_NAME;
          n_res          = 2'd2;
          state_d        = ST_IDLE;
        end else if (is_space(c)) begin
          res0.span_kind = SPAN_NAME;
          n_res          = 2'd1;
          state_d        = ST_AFTER_NAME;
        end
      end
      ST_AFTER_NAME: begin
        if (!is_space(c)) begin
          if (c == CH_GT) begin
            n_res   = 2'd1;
            state_d = ST_IDLE;
          end else if (up == kw_char(1'b0, 3'd0) || up == kw_char(1'b1, 3'd0)) begin
            kw_sys_d     = (up == kw_char(1'b1, 3'd0));
            kw_idx_d     = 3'd1;
            span_start_d = off;
            state_d      = ST_KEYWORD;
          end else begin
            state_d = ST_BOGUS;
          end
        end
      end
      ST_KEYWORD: begin
        if (kw_idx_d <= KW_LAST && up == kw_char(kw_sys_d, kw_idx_d)) begin
          if (kw_idx_d == KW_LAST) begin
            res0.span_kind = kw_sys_d ? SPAN_SYS_KW : SPAN_PUB_KW;
            n_res          = 2'd1;
            kw_idx_d       = 3'd0;
            state_d        = kw_sys_d ? ST_AFTER_PUBID : ST_BEFORE_PUBID;
          end else begin
            kw_idx_d = kw_idx_d + 3'd1;
          end
        end else begin
          kw_idx_d = 3'd0;
          state_d  = ST_BOGUS;
          if (c == CH_GT) begin
            n_res   = 2'd1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_BEFORE_PUBID, ST_AFTER_PUBID: begin
        if (!is_space(c)) begin
          if (c == CH_DQUOT || c == CH_SQUOT) begin
            q_single_d   = (c == CH_SQUOT);
            span_start_d = off + OB'(1);
            state_d      = (st == ST_BEFORE_PUBID) ? ST_PUB_ID : ST_SYS_ID;
          end else if (c == CH_GT) begin
            if (st == ST_BEFORE_PUBID) quirks_d = 1'b1;
            n_res   = 2'd1;
            state_d = ST_IDLE;
          end else begin
            if (st == ST_AFTER_PUBID) quirks_d = 1'b1;
            state_d = ST_BOGUS;
          end
        end
      end
      ST_PUB_ID, ST_SYS_ID: begin
        res0.span_kind = (st == ST_PUB_ID) ? SPAN_PUB_ID : SPAN_SYS_ID;
        if (c == quote_ch) begin
          n_res   = 2'd1;
          state_d = (st == ST_PUB_ID) ? ST_AFTER_PUBID : ST_AFTER_SYSID;
        end else if (c == CH_GT) begin
          // unterminated identifier: report what we have, then end
          quirks_d = 1'b1;
          n_res    = 2'd2;
          state_d  = ST_IDLE;
        end
      end
      ST_AFTER_SYSID: begin
        if (!is_space(c)) begin
          if (c == CH_GT) begin
            n_res   = 2'd1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_BOGUS;
          end
        end
      end
      ST_BOGUS: begin
        if (c == CH_GT) begin
          n_res   = 2'd1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // build the records; a token end is always the last event of its byte
    begin
      result_t span_r, end_r;
      span_r              = '0;
      span_r.event_kind   = EV_SPAN;
      span_r.span_kind    = res0.span_kind;
      span_r.span_begin   = 32'(span_start_d);
      span_r.span_length  = 32'(OB'(off - span_start_d));
      end_r               = '0;
      end_r.event_kind    = EV_END;
      end_r.token_length  = 32'(OB'(off - tok_start_d + OB'(1)));
      end_r.quirks_mode   = quirks_d;
      end_r.last_event    = 1'b1;
      if (st == ST_KEYWORD) span_r.span_length = 32'd6;
      if (n_res == 2'd2) begin
        res0 = span_r;
        res1 = end_r;
      end else if (state_d == ST_IDLE && st != ST_IDLE) begin
        res0 = end_r;
      end else begin
        res0            = span_r;
        res0.last_event = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kw_idx_q     <= 3'd0;
      kw_sys_q     <= 1'b0;
      q_single_q   <= 1'b0;
      span_start_q <= '0;
      tok_start_q  <= '0;
      quirks_q     <= 1'b0;
    end else if (in_accept) begin
      state_q      <= state_d;
      kw_idx_q     <= kw_idx_d;
      kw_sys_q     <= kw_sys_d;
      q_single_q   <= q_single_d;
      span_start_q <= span_start_d;
      tok_start_q  <= tok_start_d;
      quirks_q     <= quirks_d;
    end
  end

  // result queue
  logic [2:0] push_n;
  assign push_n = in_accept ? {1'b0, n_res} : 3'd0;

  always_ff @(posedge clk_i) begin
    if (push_n != 3'd0) mem_q[wr_ptr_q] <= res0;
    if (push_n == 3'd2) mem_q[wr_ptr_q + 2'd1] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[1:0];
      if (out_pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + push_n - {2'b00, out_pop};
    end
  end

  assign event_kind_o   = mem_q[rd_ptr_q].event_kind;
  assign span_kind_o    = mem_q[rd_ptr_q].span_kind;
  assign span_begin_o   = mem_q[rd_ptr_q].span_begin;
  assign span_length_o  = mem_q[rd_ptr_q].span_length;
  assign token_length_o = mem_q[rd_ptr_q].token_length;
  assign quirks_mode_o  = mem_q[rd_ptr_q].quirks_mode;
  assign last_event_o   = mem_q[rd_ptr_q].last_event;

endmodule

// ===== verif/tb_doctype_token_scanner.sv =====
`timescale 1ns / 1ps
// testbench for doctype_token_scanner: directed table, then random doctype tokens
// depends on dts_pkg and the scanner rtl; events checked against an in-bench scan model
module tb_doctype_token_scanner;
  import dts_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 450;

  // how a directed row is checked
  localparam logic [1:0] ROW_PREDICT = 2'd0;
  localparam logic [1:0] ROW_NONE    = 2'd1;
  localparam logic [1:0] ROW_END     = 2'd2;

  localparam logic [47:0] WORD_PUBLIC = "PUBLIC";
  localparam logic [47:0] WORD_SYSTEM = "SYSTEM";

  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] off;
    logic        start;
    logic [31:0] tag;
    logic [1:0]  form;
    logic [31:0] tlen;
    logic        quirk;
  } byte_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic [31:0] byte_offset_i;
  logic        start_token_i;
  logic [31:0] tag_begin_offset_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        event_kind_o;
  logic [2:0]  span_kind_o;
  logic [31:0] span_begin_o;
  logic [31:0] span_length_o;
  logic [31:0] token_length_o;
  logic        quirks_mode_o;
  logic        last_event_o;

  byte_item_t in_item = '0;

  assign data_byte_i        = in_item.data;
  assign byte_offset_i      = in_item.off;
  assign start_token_i      = in_item.start;
  assign tag_begin_offset_i = in_item.tag;

  doctype_token_scanner DUT (.*);

  always #10 clk_i = ~clk_i;

  // scan model state
  scan_state_e sc_state     = ST_IDLE;
  logic [2:0]  kw_pos       = 3'd0;
  logic        kw_sys       = 1'b0;
  logic        quote_single = 1'b0;
  logic [31:0] span_org     = 32'd0;
  logic [31:0] tok_org      = 32'd0;
  logic        quirk        = 1'b0;

  result_t     due_events[$];
  result_t     fresh_events[$];
  logic [7:0]  token_bytes[$];

  int          fail_count     = 0;
  int          cycles         = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  bit          hold_req       = 1'b0;
  int          scanned        = 0;
  logic [31:0] doc_pos        = 32'd0;

  byte_item_t directed_rows [25] = '{
    '{8'hFF,    32'h0000_0000, 1'b0, 32'h0000_0000, ROW_NONE,    32'd0,  1'b0},
    '{CH_GT,    32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, ROW_NONE,    32'd0,  1'b0},
    '{CH_GT,    32'd5,         1'b1, 32'd0,         ROW_END,     32'd6,  1'b1},
    '{8'h20,    32'd100,       1'b1, 32'd91,        ROW_PREDICT, 32'd0,  1'b0},
    '{"h",      32'd101,       1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{CH_GT,    32'd102,       1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"x",      32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFF0, ROW_PREDICT, 32'd0,  1'b0},
    '{8'h0A,    32'hFFFF_FFFF, 1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"p",      32'd0,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"U",      32'd1,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"b",      32'd2,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"L",      32'd3,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"i",      32'd4,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"C",      32'd5,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{CH_DQUOT, 32'd6,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{8'h00,    32'd7,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{CH_GT,    32'd8,         1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"n",      32'd200,       1'b1, 32'd190,       ROW_PREDICT, 32'd0,  1'b0},
    '{8'h09,    32'd201,       1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"s",      32'd202,       1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{"y",      32'd203,       1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{CH_GT,    32'd204,       1'b0, 32'd0,         ROW_END,     32'd15, 1'b0},
    '{"a",      32'd300,       1'b1, 32'd300,       ROW_PREDICT, 32'd0,  1'b0},
    '{8'h80,    32'd301,       1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0},
    '{CH_GT,    32'd302,       1'b0, 32'd0,         ROW_PREDICT, 32'd0,  1'b0}
  };

  function automatic logic blank(input logic [7:0] c);
    return c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D || c == 8'h20;
  endfunction

  function automatic logic [7:0] kw_letter(input logic sys, input logic [2:0] idx);
    logic [47:0] w;
    w = sys ? WORD_SYSTEM : WORD_PUBLIC;
    return w[47 - 8 * int'(idx) -: 8];
  endfunction

  function automatic result_t span_ev(input logic [2:0] kind, input logic [31:0] off);
    result_t r;
    r             = '0;
    r.event_kind  = EV_SPAN;
    r.span_kind   = kind;
    r.span_begin  = span_org;
    r.span_length = off - span_org;
    return r;
  endfunction

  // closes the token and drops back to idle
  function automatic result_t end_ev(input logic [31:0] off);
    result_t r;
    r              = '0;
    r.event_kind   = EV_END;
    r.token_length = off - tok_org + 32'd1;
    r.quirks_mode  = quirk;
    sc_state       = ST_IDLE;
    return r;
  endfunction

  function automatic void open_id(input logic [7:0] c, input logic [31:0] off,
                                  input scan_state_e nxt);
    quote_single = (c == CH_SQUOT);
    span_org     = off + 32'd1;
    sc_state     = nxt;
  endfunction

  task automatic scan_byte(input logic [7:0] c, input logic [31:0] off, input logic st,
                           input logic [31:0] tag);
    logic [7:0] up;
    logic [7:0] qch;
    logic [2:0] kind;
    result_t    r;
    fresh_events.delete();
    up  = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    qch = quote_single ? CH_SQUOT : CH_DQUOT;
    if (st) begin
      tok_org      = tag;
      quirk        = 1'b0;
      kw_pos       = 3'd0;
      kw_sys       = 1'b0;
      quote_single = 1'b0;
      span_org     = 32'd0;
      sc_state     = ST_BEFORE_NAME;
    end
    case (sc_state)
      ST_BEFORE_NAME: if (!blank(c)) begin
        if (c == CH_GT) begin
          quirk = 1'b1;
          fresh_events.push_back(end_ev(off));
        end else begin
          span_org = off;
          sc_state = ST_NAME;
        end
      end
      ST_NAME: if (c == CH_GT) begin
        fresh_events.push_back(span_ev(SPAN_NAME, off));
        fresh_events.push_back(end_ev(off));
      end else if (blank(c)) begin
        fresh_events.push_back(span_ev(SPAN_NAME, off));
        sc_state = ST_AFTER_NAME;
      end
      ST_AFTER_NAME: if (!blank(c)) begin
        if (c == CH_GT) begin
          fresh_events.push_back(end_ev(off));
        end else if (up == kw_letter(1'b0, 3'd0) || up == kw_letter(1'b1, 3'd0)) begin
          kw_sys   = (up == kw_letter(1'b1, 3'd0));
          kw_pos   = 3'd1;
          span_org = off;
          sc_state = ST_KEYWORD;
        end else begin
          sc_state = ST_BOGUS;
        end
      end
      ST_KEYWORD: if (up == kw_letter(kw_sys, kw_pos)) begin
        if (kw_pos == KW_LAST) begin
          r             = span_ev(kw_sys ? SPAN_SYS_KW : SPAN_PUB_KW, off);
          r.span_length = 32'd6;
          fresh_events.push_back(r);
          kw_pos   = 3'd0;
          sc_state = kw_sys ? ST_AFTER_PUBID : ST_BEFORE_PUBID;
        end else begin
          kw_pos = kw_pos + 3'd1;
        end
      end else begin
        kw_pos   = 3'd0;
        sc_state = ST_BOGUS;
        if (c == CH_GT) fresh_events.push_back(end_ev(off));
      end
      ST_BEFORE_PUBID: if (!blank(c)) begin
        if (c == CH_DQUOT || c == CH_SQUOT) begin
          open_id(c, off, ST_PUB_ID);
        end else if (c == CH_GT) begin
          quirk = 1'b1;
          fresh_events.push_back(end_ev(off));
        end else begin
          sc_state = ST_BOGUS;
        end
      end
      ST_PUB_ID, ST_SYS_ID: begin
        kind = (sc_state == ST_PUB_ID) ? SPAN_PUB_ID : SPAN_SYS_ID;
        if (c == qch) begin
          fresh_events.push_back(span_ev(kind, off));
          sc_state = (kind == SPAN_PUB_ID) ? ST_AFTER_PUBID : ST_AFTER_SYSID;
        end else if (c == CH_GT) begin
          quirk = 1'b1;
          fresh_events.push_back(span_ev(kind, off));
          fresh_events.push_back(end_ev(off));
        end
      end
      ST_AFTER_PUBID: if (!blank(c)) begin
        if (c == CH_DQUOT || c == CH_SQUOT) begin
          open_id(c, off, ST_SYS_ID);
        end else if (c == CH_GT) begin
          fresh_events.push_back(end_ev(off));
        end else begin
          quirk    = 1'b1;
          sc_state = ST_BOGUS;
        end
      end
      ST_AFTER_SYSID: if (!blank(c)) begin
        if (c == CH_GT) fresh_events.push_back(end_ev(off));
        else sc_state = ST_BOGUS;
      end
      ST_BOGUS: if (c == CH_GT) begin
        fresh_events.push_back(end_ev(off));
      end
      default: sc_state = ST_IDLE;
    endcase
  endtask

  task automatic check_event(input result_t want, input result_t got);
    if (got !== want) begin
      fail_count++;
      $display("%0t mismatch: expected ev %0d kind %0d begin %h len %0d tlen %0d q %0d last %0d",
               $time, want.event_kind, want.span_kind, want.span_begin, want.span_length,
               want.token_length, want.quirks_mode, want.last_event);
      $display("%0t           actual ev %0d kind %0d begin %h len %0d tlen %0d q %0d last %0d",
               $time, got.event_kind, got.span_kind, got.span_begin, got.span_length,
               got.token_length, got.quirks_mode, got.last_event);
    end
  endtask

  // prediction on accepted items, checking on accepted events
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        scan_byte(in_item.data, in_item.off, in_item.start, in_item.tag);
        case (in_item.form)
          ROW_PREDICT: foreach (fresh_events[i]) begin
            want            = fresh_events[i];
            want.last_event = (i == fresh_events.size() - 1);
            due_events.push_back(want);
          end
          ROW_END: begin
            want              = '0;
            want.event_kind   = EV_END;
            want.token_length = in_item.tlen;
            want.quirks_mode  = in_item.quirk;
            want.last_event   = 1'b1;
            due_events.push_back(want);
          end
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        got = {event_kind_o, span_kind_o, span_begin_o, span_length_o, token_length_o,
               quirks_mode_o, last_event_o};
        if (due_events.size() == 0) begin
          fail_count++;
          $display("%0t unexpected event: expected none, actual ev %0d kind %0d tlen %0d",
                   $time, got.event_kind, got.span_kind, got.token_length);
        end else begin
          want = due_events.pop_front();
          check_event(want, got);
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input byte_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_item    <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(4))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0C;
      3:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    do begin
      c = $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom_range(255));
    end while (blank(c) || c == CH_GT);
    return c;
  endfunction

  task automatic add_quoted();
    logic [7:0] qc;
    logic [7:0] c;
    qc = $urandom_range(1) ? CH_SQUOT : CH_DQUOT;
    token_bytes.push_back(qc);
    repeat ($urandom_range(5)) begin
      c = 8'($urandom_range(255));
      token_bytes.push_back(c == qc ? 8'h61 : c);
    end
    token_bytes.push_back(qc);
  endtask

  // mostly well-formed doctype bodies, some of them damaged or cut short
  task automatic build_token();
    int   style;
    int   n;
    logic sys;
    token_bytes.delete();
    repeat ($urandom_range(2)) token_bytes.push_back(pick_blank());
    style = $urandom_range(9);
    if (style != 0) begin
      repeat ($urandom_range(1, 6)) token_bytes.push_back(pick_name_char());
      if (style != 1) begin
        repeat ($urandom_range(1, 2)) token_bytes.push_back(pick_blank());
        sys = 1'($urandom_range(1));
        for (int i = 0; i < 6; i++) begin
          token_bytes.push_back(kw_letter(sys, 3'(i)) | ($urandom_range(1) ? 8'h20 : 8'h00));
        end
        repeat ($urandom_range(2)) token_bytes.push_back(pick_blank());
        add_quoted();
        if (!sys && $urandom_range(3) != 0) begin
          repeat ($urandom_range(2)) token_bytes.push_back(pick_blank());
          add_quoted();
        end
        if ($urandom_range(9) == 0) token_bytes.push_back(pick_name_char());
        repeat ($urandom_range(2)) token_bytes.push_back(pick_blank());
      end
    end
    token_bytes.push_back(CH_GT);
    if ($urandom_range(99) < 25) begin
      n = $urandom_range(token_bytes.size() - 1);
      case ($urandom_range(3))
        0: token_bytes[n] = 8'($urandom_range(255));
        1: token_bytes[n] = CH_GT;
        2: token_bytes[n] = $urandom_range(1) ? CH_SQUOT : CH_DQUOT;
        default: while (token_bytes.size() > n) void'(token_bytes.pop_back());
      endcase
    end
  endtask

  task automatic send_token();
    byte_item_t  it;
    logic [31:0] tag_org;
    case ($urandom_range(15))
      0:       doc_pos = $urandom;
      1:       doc_pos = 32'hFFFF_FFF8;
      default: ;
    endcase
    tag_org = ($urandom_range(7) == 0) ? $urandom : doc_pos - 32'd9;
    foreach (token_bytes[i]) begin
      // a jump between buffer chunks now and then
      if ($urandom_range(31) == 0) doc_pos = doc_pos + $urandom_range(1, 1000);
      it       = '0;
      it.data  = token_bytes[i];
      it.off   = doc_pos;
      it.start = (i == 0);
      it.tag   = (i == 0) ? tag_org : $urandom;
      it.form  = ROW_PREDICT;
      send_item(it);
      doc_pos++;
      scanned++;
    end
    if ($urandom_range(9) < 3) begin
      repeat ($urandom_range(1, 3)) begin
        it      = '0;
        it.data = 8'($urandom_range(255));
        it.off  = doc_pos;
        it.tag  = $urandom;
        it.form = ROW_PREDICT;
        send_item(it);
        doc_pos++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    doc_pos = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      while (scanned < (ph + 1) * RANDOM_ITEMS / 4) begin
        build_token();
        send_token();
      end
    end
    in_valid_i <= 1'b0;

    while (due_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
